// ===== sv/serial_char_to_lcd_line_editor_top_assert.svh =====
// assertion macros for the serial character to lcd line editor
// used by the port checker; expects clk and arst_n in the enclosing scope
`ifndef SERIAL_CHAR_TO_LCD_LINE_EDITOR_TOP_ASSERT_SVH
`define SERIAL_CHAR_TO_LCD_LINE_EDITOR_TOP_ASSERT_SVH

// generic property check, off while in reset
`define SCLCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// a signal is unchanged in the cycle after the condition
`define SCLCD_HOLD(lbl, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

// ===== sv/sclcd_pkg.sv =====
// shared types and constants of the serial character to lcd line editor
// no dependencies
package sclcd_pkg;

	// width of the cursor column
	localparam int COL_W = 5;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// character codes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// lcd command: cursor to second line, low nibble is the column
	localparam logic [7:0] CMD_LINE2 = 8'hC0;

	// reset value of the idle restart register
	localparam logic [15:0] IDLE_RESTART_RESET = 16'd300;

	// operation codes on the input channel
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// editing action of one character
	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_ERASE,
		ACT_PRINT
	} act_t;

	// one job handed from front to back
	typedef struct packed {
		logic             clear;
		act_t             act;
		logic [COL_W-1:0] col;
		logic [7:0]       chr;
	} job_t;

endpackage

// ===== sv/sclcd_if.sv =====
// valid/ready channel interfaces for serial input words and lcd output words
// no dependencies
interface sclcd_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] char_code;

	modport source (output valid, output operation, output char_code, input ready);
	modport sink (input valid, input operation, input char_code, output ready);
endinterface

interface sclcd_out_if;
	logic       valid;
	logic       ready;
	logic       is_command;
	logic [7:0] lcd_byte;
	logic       last;

	modport source (output valid, output is_command, output lcd_byte, output last, input ready);
	modport sink (input valid, input is_command, input lcd_byte, input last, output ready);
endinterface

// ===== sv/sclcd_fifo.sv =====
// short job queue between the classifying front and the byte sequencer
// depends on sclcd_pkg
module sclcd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sclcd_pkg::job_t   push_job,
	output logic              full,
	input  logic              pop,
	output sclcd_pkg::job_t   pop_job,
	output logic              not_empty
);
	import sclcd_pkg::*;

	localparam logic [QPTR_W:0] CNT_FULL = (QPTR_W+1)'(QUEUE_DEPTH);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign pop_job   = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== sv/sclcd_front.sv =====
// front: accepts serial words, keeps editor state and turns characters into jobs
// depends on sclcd_pkg and sclcd_if
module sclcd_front #(
	parameter int LINE_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	sclcd_in_if.sink        rx,
	output logic            push,
	output sclcd_pkg::job_t job,
	input  logic            full
);
	import sclcd_pkg::*;

	logic [15:0]      restart_q;
	logic [15:0]      idle_cnt_q;
	logic [COL_W-1:0] col_q;
	logic             msg_pend_q;

	logic             acc;
	logic             pend;
	logic [COL_W-1:0] col_base;
	logic [COL_W-1:0] col_nx;
	logic             msg_nx;
	logic [7:0]       ch;

	assign rx.ready = !full;
	assign acc      = rx.valid && rx.ready;
	assign ch       = rx.char_code;

	// classify the character against the current state
	always_comb begin
		pend      = msg_pend_q || (idle_cnt_q == '0);
		col_base  = pend ? '0 : col_q;
		col_nx    = col_base;
		msg_nx    = 1'b0;
		job.clear = pend;
		job.act   = ACT_NONE;
		job.col   = col_base;
		job.chr   = ch;
		if (ch == CH_CR) begin
			msg_nx = 1'b0;
		end else if (ch == CH_LF) begin
			msg_nx = 1'b1;
		end else if (ch == CH_BS || ch == CH_DEL) begin
			if (col_base != '0) begin
				col_nx  = col_base - 1'b1;
				job.act = ACT_ERASE;
				job.col = col_base - 1'b1;
			end
		end else if (ch inside {[CH_SPACE:CH_TILDE]}) begin
			if (col_base < COL_W'(LINE_WIDTH)) begin
				col_nx  = col_base + 1'b1;
				job.act = ACT_PRINT;
			end
		end
	end

	// only characters that give bytes go to the queue
	assign push = acc && (rx.operation == OP_CHAR) && (job.clear || job.act != ACT_NONE);

	// restart register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= IDLE_RESTART_RESET;
		end else if (cfg_we) begin
			restart_q <= cfg_wdata;
		end
	end

	// editor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cnt_q <= '0;
			col_q      <= '0;
			msg_pend_q <= 1'b1;
		end else if (acc) begin
			if (rx.operation == OP_TICK) begin
				if (idle_cnt_q != '0) begin
					idle_cnt_q <= idle_cnt_q - 1'b1;
				end
			end else begin
				idle_cnt_q <= restart_q;
				col_q      <= col_nx;
				msg_pend_q <= msg_nx;
			end
		end
	end
endmodule

// ===== sv/sclcd_back.sv =====
// back: plays one job out as a sequence of lcd command and data words
// depends on sclcd_pkg and sclcd_if
module sclcd_back #(
	parameter int LINE_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  sclcd_pkg::job_t q_job,
	output logic            q_pop,
	sclcd_out_if.source     lcd
);
	import sclcd_pkg::*;

	localparam int              CNT_W   = $clog2(LINE_WIDTH + 2);
	localparam logic [CNT_W-1:0] CLR_END = CNT_W'(LINE_WIDTH + 1);
	localparam logic [CNT_W-1:0] ACT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] ACT_END = CNT_W'(2);

	// sequencer states
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_CLEAR = 2'd1;
	localparam logic [1:0] PH_ACT   = 2'd2;

	logic [1:0]       ph_q;
	logic [CNT_W-1:0] cnt_q;
	job_t             job_q;

	logic             out_vld_q;
	logic             out_cmd_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic             g_cmd;
	logic [7:0]       g_byte;
	logic             g_fin;
	logic             g_last;
	logic             adv;
	logic             done;
	logic [7:0]       cur_cmd;

	assign cur_cmd = CMD_LINE2 | {4'b0000, job_q.col[3:0]};

	// word for the current step
	always_comb begin
		g_cmd  = 1'b0;
		g_byte = CH_SPACE;
		g_fin  = 1'b0;
		g_last = 1'b0;
		case (ph_q)
			PH_CLEAR: begin
				g_cmd  = (cnt_q == '0) || (cnt_q == CLR_END);
				g_byte = g_cmd ? CMD_LINE2 : CH_SPACE;
				g_fin  = (cnt_q == CLR_END);
				g_last = g_fin && (job_q.act == ACT_NONE);
			end
			PH_ACT: begin
				if (cnt_q == ACT_ONE) begin
					g_cmd  = 1'b0;
					g_byte = (job_q.act == ACT_PRINT) ? job_q.chr : CH_SPACE;
				end else begin
					g_cmd  = 1'b1;
					g_byte = cur_cmd;
				end
				g_fin  = (cnt_q == ACT_END) || (cnt_q == ACT_ONE && job_q.act == ACT_PRINT);
				g_last = g_fin;
			end
			default: begin
				g_cmd  = 1'b0;
				g_byte = CH_SPACE;
				g_fin  = 1'b0;
				g_last = 1'b0;
			end
		endcase
	end

	assign adv   = (ph_q != PH_IDLE) && (!out_vld_q || lcd.ready);
	assign done  = adv && g_last;
	assign q_pop = q_valid && ((ph_q == PH_IDLE) || done);

	// sequencer, a new job takes over as the old one finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			cnt_q <= '0;
		end else if (q_pop) begin
			ph_q  <= q_job.clear ? PH_CLEAR : PH_ACT;
			cnt_q <= '0;
		end else if (adv) begin
			if (done) begin
				ph_q <= PH_IDLE;
			end else if (g_fin) begin
				ph_q  <= PH_ACT;
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// job register
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (lcd.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_cmd_q  <= g_cmd;
			out_byte_q <= g_byte;
			out_last_q <= g_last;
		end
	end

	assign lcd.valid      = out_vld_q;
	assign lcd.is_command = out_cmd_q;
	assign lcd.lcd_byte   = out_byte_q;
	assign lcd.last       = out_last_q;
endmodule

// ===== sv/serial_char_to_lcd_line_editor_top.sv =====
// top level of the serial character to lcd line editor
// depends on sclcd_pkg, sclcd_if, sclcd_front, sclcd_fifo and sclcd_back
//
// rx carries serial words: operation 0 is a received character in char_code,
// operation 1 is one idle tick. lcd carries the byte stream for the lcd second
// line: is_command selects the command register, last marks the final word
// caused by one rx word. both use valid/ready; a word moves when both are high.
// cfg_we/cfg_wdata write the idle restart tick count; write it only when idle.
// a character gives 0 to 20 lcd words: a pending line clear is 18 words
// (cursor, LINE_WIDTH spaces, cursor), then print gives 2 and erase gives 3.
// the back sequencer emits one word per cycle while lcd does not stall, with no
// gap between queued jobs. the first word of an item passes the queue, the
// sequencer state and the output register. ticks and silent characters skip the queue.
// a two-entry job queue lets rx keep flowing while lcd is stalled; rx.ready
// drops only when the queue is full. a stalled lcd word holds its payload.
// reset clears the queue and output, sets column 0, a pending clear, idle count
// zero and restart count 300; no clearing pass is needed.
module serial_char_to_lcd_line_editor_top #(
	parameter int LINE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	sclcd_in_if.sink    rx,
	sclcd_out_if.source lcd
);
	import sclcd_pkg::*;

	logic push;
	job_t push_job;
	logic full;
	logic pop;
	job_t pop_job;
	logic not_empty;

	// classify characters
	sclcd_front #(
		.LINE_WIDTH (LINE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx),
		.push      (push),
		.job       (push_job),
		.full      (full)
	);

	// job queue
	sclcd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (full),
		.pop       (pop),
		.pop_job   (pop_job),
		.not_empty (not_empty)
	);

	// emit lcd words
	sclcd_back #(
		.LINE_WIDTH (LINE_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (not_empty),
		.q_job   (pop_job),
		.q_pop   (pop),
		.lcd     (lcd)
	);
endmodule

// ===== sv/sclcd_checker.sv =====
// port checker for the serial character to lcd line editor, bound to the top
// depends on sclcd_pkg and serial_char_to_lcd_line_editor_top_assert.svh
`include "serial_char_to_lcd_line_editor_top_assert.svh"

module sclcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       lcd_valid,
	input logic       lcd_ready,
	input logic       lcd_is_command,
	input logic [7:0] lcd_byte,
	input logic       lcd_last
);
	import sclcd_pkg::*;

	// cursor commands always address the second line
	`SCLCD_ASSERT(a_cmd_line2, lcd_valid && lcd_is_command |-> lcd_byte[7:4] == CMD_LINE2[7:4], "lcd command is not a second line cursor")

	// data words are printable characters only
	`SCLCD_ASSERT(a_data_printable, lcd_valid && !lcd_is_command |-> (lcd_byte >= CH_SPACE && lcd_byte <= CH_TILDE), "lcd data word is not printable")

	// a stalled word keeps its payload
	`SCLCD_HOLD(a_stall_hold, lcd_valid && !lcd_ready, {lcd_valid, lcd_is_command, lcd_byte, lcd_last}, "lcd word changed while stalled")
endmodule

bind serial_char_to_lcd_line_editor_top sclcd_checker u_sclcd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.lcd_valid      (lcd.valid),
	.lcd_ready      (lcd.ready),
	.lcd_is_command (lcd.is_command),
	.lcd_byte       (lcd.lcd_byte),
	.lcd_last       (lcd.last)
);

// ===== test/testbench.sv =====
// testbench for serial_char_to_lcd_line_editor_top: random and directed serial words
// against a line-editor predictor; depends on sclcd_pkg, sclcd_if and the rtl top
`timescale 1ns / 1ps

module testbench;
	import sclcd_pkg::*;

	localparam int LINE_WIDTH  = 16;
	localparam int CYCLE_LIMIT = 2_000_000;

	// one lcd word as it leaves the block
	typedef struct packed {
		logic       is_command;
		logic [7:0] lcd_byte;
		logic       last;
	} lcd_word_t;

	// line editor predictor and queue of expected lcd words
	class lcd_scoreboard;
		lcd_word_t        expected_words[$];
		logic [COL_W-1:0] column;
		logic             clear_pending;
		logic [15:0]      idle_left;
		logic [15:0]      restart_ticks;
		int               errors;

		function new();
			column        = '0;
			clear_pending = 1'b1;
			idle_left     = '0;
			restart_ticks = IDLE_RESTART_RESET;
			errors        = 0;
		endfunction

		function void set_restart(logic [15:0] ticks);
			restart_ticks = ticks;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		// work out the lcd words caused by one accepted serial word
		function void note_rx(logic op, logic [7:0] ch);
			lcd_word_t batch[$];
			if (op == OP_TICK) begin
				if (idle_left != 0)
					idle_left--;
				return;
			end
			if (idle_left == 0)
				clear_pending = 1'b1;
			// line clear: cursor home, blanks, cursor home
			if (clear_pending) begin
				batch.push_back('{1'b1, CMD_LINE2, 1'b0});
				for (int i = 0; i < LINE_WIDTH; i++)
					batch.push_back('{1'b0, CH_SPACE, 1'b0});
				batch.push_back('{1'b1, CMD_LINE2, 1'b0});
				column        = '0;
				clear_pending = 1'b0;
			end
			if (ch == CH_CR) begin
				// carriage return does nothing
			end else if (ch == CH_LF) begin
				clear_pending = 1'b1;
			end else if (ch == CH_BS || ch == CH_DEL) begin
				if (column != 0) begin
					column = column - 1'b1;
					batch.push_back('{1'b1, CMD_LINE2 | {4'b0, column[3:0]}, 1'b0});
					batch.push_back('{1'b0, CH_SPACE, 1'b0});
					batch.push_back('{1'b1, CMD_LINE2 | {4'b0, column[3:0]}, 1'b0});
				end
			end else if (ch >= CH_SPACE && ch <= CH_TILDE) begin
				if (column < LINE_WIDTH) begin
					batch.push_back('{1'b1, CMD_LINE2 | {4'b0, column[3:0]}, 1'b0});
					batch.push_back('{1'b0, ch, 1'b0});
					column = column + 1'b1;
				end
			end
			idle_left = restart_ticks;
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i])
				expected_words.push_back(batch[i]);
		endfunction

		// compare one accepted lcd word with the oldest expectation
		function void check_word(logic is_command, logic [7:0] lcd_byte, logic last);
			lcd_word_t exp_word;
			if (expected_words.size() == 0) begin
				$error("unexpected lcd word: is_command %0d, lcd_byte 0x%02h, last %0d",
					is_command, lcd_byte, last);
				errors++;
				return;
			end
			exp_word = expected_words.pop_front();
			if (is_command !== exp_word.is_command) begin
				$error("is_command: expected %0d, actual %0d", exp_word.is_command, is_command);
				errors++;
			end
			if (lcd_byte !== exp_word.lcd_byte) begin
				$error("lcd_byte: expected 0x%02h, actual 0x%02h", exp_word.lcd_byte, lcd_byte);
				errors++;
			end
			if (last !== exp_word.last) begin
				$error("last: expected %0d, actual %0d", exp_word.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	sclcd_in_if  rx_bus();
	sclcd_out_if lcd_bus();

	lcd_scoreboard sb = new();

	int          rx_gap_pct;
	int          lcd_stall_pct;
	int          lcd_hold_cycles;
	int          items_sent;
	int          cycle_count;
	logic [15:0] restart_now;

	serial_char_to_lcd_line_editor_top #(
		.LINE_WIDTH(LINE_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.rx(rx_bus),
		.lcd(lcd_bus)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		if ($urandom_range(99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// lcd receiver: check accepted words, then choose ready for the next cycle
	initial begin
		int stall_left;
		stall_left = 0;
		lcd_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && lcd_bus.valid && lcd_bus.ready)
				sb.check_word(lcd_bus.is_command, lcd_bus.lcd_byte, lcd_bus.last);
			if (lcd_hold_cycles > 0) begin
				lcd_hold_cycles--;
				lcd_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				lcd_bus.ready <= 1'b0;
			end else if ($urandom_range(99) < lcd_stall_pct) begin
				stall_left = pick_gap() - 1;
				lcd_bus.ready <= 1'b0;
			end else begin
				lcd_bus.ready <= 1'b1;
			end
		end
	end

	// offer one serial word, return at the edge where it is accepted
	task automatic send_word(logic op, logic [7:0] ch);
		int gap;
		gap = ($urandom_range(99) < rx_gap_pct) ? pick_gap() : 0;
		if (gap > 0) begin
			rx_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_bus.valid     <= 1'b1;
		rx_bus.operation <= op;
		rx_bus.char_code <= ch;
		@(posedge clk);
		while (!rx_bus.ready)
			@(posedge clk);
		sb.note_rx(op, ch);
		items_sent++;
	endtask

	task automatic send_ticks(int count);
		repeat (count) send_word(OP_TICK, 8'($urandom_range(255)));
	endtask

	// wait until every expected word has come and the block has drained
	task automatic settle();
		rx_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_restart(logic [15:0] ticks);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= ticks;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_restart(ticks);
		restart_now = ticks;
	endtask

	// printable text with a few erases, usually closed by a line feed
	task automatic send_message();
		int len;
		len = ($urandom_range(4) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 12);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(7) == 0)
				send_word(OP_CHAR, $urandom_range(1) ? CH_BS : CH_DEL);
			send_word(OP_CHAR, 8'($urandom_range(int'(CH_SPACE), int'(CH_TILDE))));
		end
		case ($urandom_range(3))
			0, 1: send_word(OP_CHAR, CH_LF);
			2: begin
				send_word(OP_CHAR, CH_CR);
				send_word(OP_CHAR, CH_LF);
			end
			default: ;
		endcase
	endtask

	// idle ticks, sometimes right around a small restart count
	task automatic send_idle();
		int count;
		if (restart_now <= 40 && $urandom_range(1) == 1) begin
			count = int'(restart_now) - 1 + $urandom_range(2);
			if (count < 0)
				count = 0;
		end else begin
			count = $urandom_range(1, 5);
		end
		send_ticks(count);
	endtask

	// random traffic until the phase has sent its share of serial words
	task automatic run_phase(int item_budget);
		int stop_at;
		stop_at = items_sent + item_budget;
		while (items_sent < stop_at) begin
			case ($urandom_range(19))
				0, 1, 2:
					send_word($urandom_range(4) == 0 ? OP_TICK : OP_CHAR,
						8'($urandom_range(255)));
				3, 4:
					send_idle();
				default:
					send_message();
			endcase
		end
	endtask

	// main sequence
	initial begin
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_wdata        <= '0;
		rx_bus.valid     <= 1'b0;
		rx_bus.operation <= OP_CHAR;
		rx_bus.char_code <= '0;
		rx_gap_pct      = 20;
		lcd_stall_pct   = 20;
		lcd_hold_cycles = 0;
		items_sent      = 0;
		restart_now     = IDLE_RESTART_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: print extremes, erases, ignored and dropped bytes
		send_word(OP_CHAR, CH_SPACE);
		send_word(OP_CHAR, CH_TILDE);
		send_word(OP_CHAR, CH_BS);
		send_word(OP_CHAR, CH_DEL);
		send_word(OP_CHAR, CH_DEL);
		send_word(OP_CHAR, CH_CR);
		send_word(OP_CHAR, 8'h00);
		send_word(OP_CHAR, 8'hFF);
		send_word(OP_CHAR, CH_LF);
		send_word(OP_TICK, 8'hFF);
		// fill the line and run past its end
		for (int i = 0; i < LINE_WIDTH + 1; i++)
			send_word(OP_CHAR, 8'(int'("A") + i));

		// default restart count
		run_phase(70);

		// zero restart, no idling on either side
		write_restart(16'd0);
		rx_gap_pct    = 0;
		lcd_stall_pct = 0;
		run_phase(70);

		// largest restart, long receiver hold-off while words keep coming
		write_restart(16'hFFFF);
		rx_gap_pct      = 10;
		lcd_stall_pct   = 40;
		lcd_hold_cycles = 300;
		repeat (4) send_message();
		run_phase(50);

		// restart after one tick
		write_restart(16'd1);
		rx_gap_pct    = 40;
		lcd_stall_pct = 10;
		run_phase(70);

		// small random restart
		write_restart(16'($urandom_range(2, 40)));
		rx_gap_pct    = 25;
		lcd_stall_pct = 25;
		run_phase(70);

		settle();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
